FILE: hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and codes of the call session tracker: message kinds, session
// states, result codes and the layout of one session table record.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Message kinds
  localparam logic [2:0] KIND_INVITE     = 3'd0;
  localparam logic [2:0] KIND_ACK        = 3'd1;
  localparam logic [2:0] KIND_BYE        = 3'd2;
  localparam logic [2:0] KIND_STATUS_200 = 3'd3;
  localparam logic [2:0] KIND_STATUS_407 = 3'd4;
  localparam logic [2:0] KIND_STATUS_503 = 3'd5;

  // Session states
  localparam logic [3:0] ST_INVITE1     = 4'd0;
  localparam logic [3:0] ST_INVITE2     = 4'd1;
  localparam logic [3:0] ST_OK1         = 4'd2;
  localparam logic [3:0] ST_ACK1        = 4'd3;
  localparam logic [3:0] ST_AUTHREQ     = 4'd4;
  localparam logic [3:0] ST_ESTABLISHED = 4'd5;
  localparam logic [3:0] ST_REINVITE    = 4'd6;
  localparam logic [3:0] ST_REINVITEOK1 = 4'd7;
  localparam logic [3:0] ST_BYE         = 4'd8;
  localparam logic [3:0] ST_SRVUNAVAIL  = 4'd9;

  // Result codes
  localparam logic [3:0] RC_UNHANDLED     = 4'd0;
  localparam logic [3:0] RC_CREATED       = 4'd1;
  localparam logic [3:0] RC_CREATE_FAILED = 4'd2;
  localparam logic [3:0] RC_ADVANCED      = 4'd3;
  localparam logic [3:0] RC_ESTABLISHED   = 4'd4;
  localparam logic [3:0] RC_REINVITE      = 4'd5;
  localparam logic [3:0] RC_BYE           = 4'd6;
  localparam logic [3:0] RC_REMOVED       = 4'd7;
  localparam logic [3:0] RC_UNKNOWN       = 4'd8;
  localparam logic [3:0] RC_FULL          = 4'd9;
  localparam logic [3:0] RC_BAD_STATE     = 4'd10;
  localparam logic [3:0] RC_PORT_ERROR    = 4'd11;
  localparam logic [3:0] RC_UNCHANGED     = 4'd12;

  // Configuration register addresses
  localparam logic [0:0] ADDR_DIRECTION = 1'b0;

  // One session table record
  typedef struct packed {
    logic [31:0] key;
    logic [3:0]  status;
    logic [31:0] remote_ip;
    logic [31:0] local_ip;
    logic [15:0] remote_port;
    logic [15:0] local_port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/sct_ram.sv
// ----------------------------------------------------------------------------
// sct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hdl/sip_call_session_tracker_unit.sv
// ----------------------------------------------------------------------------
// sip_call_session_tracker_unit
// Session table for parsed signalling messages: looks up a call by key,
// creates, advances, rewrites or frees its entry and reports one result.
// ----------------------------------------------------------------------------
//  channel  | ports                          | transfer
//  ---------+--------------------------------+-------------------------------
//  input    | start, busy, in_*              | start high while busy is low
//  result   | out_strobe, out_*              | out_strobe high for one cycle
//  config   | psel, penable, pwrite, paddr,  | psel & penable & pwrite
//           | pwdata, prdata, pready         | (pready is always high)
//
// A message is handled by a scan of the table RAM, one slot per cycle through
// its single read port; the key compare is shared over all slots, and a hit
// ends the scan early. Kinds 6 and 7 skip the scan.
// Reset is synchronous and clears the valid bits and the direction register;
// the RAM is not cleared. The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
module sip_call_session_tracker_unit #(
  parameter int SESSIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command input
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_call_key,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic        in_addr_ok,
  input  logic [15:0] in_media_port,
  input  logic        in_port_ok,
  input  logic [31:0] in_conn_ip,
  // result output
  output logic        out_strobe,
  output logic [3:0]  out_result_code,
  output logic [3:0]  out_session_state,
  output logic [3:0]  out_slot,
  output logic [31:0] out_remote_ip,
  output logic [31:0] out_local_ip,
  output logic [15:0] out_remote_port,
  output logic [15:0] out_local_port,
  output logic [31:0] out_prior_remote_ip,
  output logic [15:0] out_prior_remote_port,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSIONS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic direction_r;

  // Latched command
  logic [2:0]  kind_r;
  logic [31:0] key_r;
  logic [31:0] src_ip_r;
  logic [31:0] dst_ip_r;
  logic        addr_ok_r;
  logic [15:0] port_r;
  logic        port_ok_r;
  logic [31:0] conn_ip_r;

  // Scan control
  logic [IDX_W-1:0] idx_r;
  logic             issue_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r;
  logic             found_r;
  logic [IDX_W-1:0] slot_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_slot_r;
  sct_pkg::entry_t  ent_r;

  // Table
  logic [SESSIONS-1:0] valid_r;
  sct_pkg::entry_t     rd_entry;
  logic [sct_pkg::ENTRY_W-1:0] rd_bits;

  // Step results
  sct_pkg::entry_t  nx;
  logic [3:0]       rc;
  logic             touch;
  logic             wr;
  logic             set_v;
  logic             clr_v;
  logic [IDX_W-1:0] wslot;
  logic [31:0]      prior_ip;
  logic [15:0]      prior_port;

  logic accept;
  logic hit;
  logic cfg_wr;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && (paddr == sct_pkg::ADDR_DIRECTION);

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == sct_pkg::ADDR_DIRECTION) ? {31'd0, direction_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else if (cfg_wr) begin
      direction_r <= pwdata[0];
    end
  end

  // Session table RAM
  sct_ram #(
    .WIDTH (sct_pkg::ENTRY_W),
    .DEPTH (SESSIONS)
  ) u_table (
    .clk   (clk),
    .we    (wr && (state_r == S_EXEC)),
    .waddr (wslot),
    .wdata (nx),
    .raddr (idx_r),
    .rdata (rd_bits)
  );

  assign rd_entry = sct_pkg::entry_t'(rd_bits);
  assign hit      = cmp_vld_r && valid_r[cmp_idx_r] && (rd_entry.key == key_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_kind > sct_pkg::KIND_STATUS_503) ? S_EXEC : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || (cmp_vld_r && (cmp_idx_r == LAST_IDX))) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the command on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      key_r     <= in_call_key;
      src_ip_r  <= in_src_ip;
      dst_ip_r  <= in_dst_ip;
      addr_ok_r <= in_addr_ok;
      port_r    <= in_media_port;
      port_ok_r <= in_port_ok;
      conn_ip_r <= in_conn_ip;
    end
  end

  // Scan the table: issue one read per cycle, compare the slot read before
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r      <= 1'b0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      idx_r        <= '0;
    end else if (accept) begin
      idx_r        <= '0;
      issue_r      <= 1'b1;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == S_SCAN) begin
      cmp_vld_r <= issue_r;
      if (hit) begin
        found_r <= 1'b1;
        slot_r  <= cmp_idx_r;
        ent_r   <= rd_entry;
        issue_r <= 1'b0;
      end else if (issue_r) begin
        cmp_idx_r <= idx_r;
        if (idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= cmp_idx_r;
      end
    end
  end

  // Apply the message to the session
  always_comb begin
    rc         = sct_pkg::RC_UNHANDLED;
    nx         = ent_r;
    touch      = 1'b0;
    wr         = 1'b0;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    wslot      = slot_r;
    prior_ip   = 32'd0;
    prior_port = 16'd0;
    if (kind_r > sct_pkg::KIND_STATUS_503) begin
      rc = sct_pkg::RC_UNHANDLED;
    end else if (!found_r) begin
      if (kind_r != sct_pkg::KIND_INVITE) begin
        rc = sct_pkg::RC_UNKNOWN;
      end else if (!(addr_ok_r && port_ok_r && (port_r != 16'd0))) begin
        rc = sct_pkg::RC_CREATE_FAILED;
      end else if (!free_found_r) begin
        rc = sct_pkg::RC_FULL;
      end else begin
        // Create a new entry, addresses swapped by direction
        rc        = sct_pkg::RC_CREATED;
        touch     = 1'b1;
        wr        = 1'b1;
        set_v     = 1'b1;
        wslot     = free_slot_r;
        nx.key    = key_r;
        nx.status = sct_pkg::ST_INVITE1;
        if (!direction_r) begin
          nx.remote_ip   = src_ip_r;
          nx.local_ip    = dst_ip_r;
          nx.remote_port = port_r;
          nx.local_port  = 16'd0;
        end else begin
          nx.remote_ip   = dst_ip_r;
          nx.local_ip    = src_ip_r;
          nx.remote_port = 16'd0;
          nx.local_port  = port_r;
        end
      end
    end else begin
      touch      = 1'b1;
      wr         = 1'b1;
      prior_ip   = ent_r.remote_ip;
      prior_port = ent_r.remote_port;
      case (kind_r)
        sct_pkg::KIND_INVITE: begin
          if ((ent_r.status == sct_pkg::ST_ESTABLISHED) ||
              (ent_r.status == sct_pkg::ST_REINVITE)) begin
            if (!direction_r && !port_ok_r) begin
              rc = sct_pkg::RC_PORT_ERROR;
            end else begin
              if (!direction_r) begin
                nx.remote_ip   = conn_ip_r;
                nx.remote_port = port_r;
              end
              nx.status = sct_pkg::ST_REINVITE;
              rc        = sct_pkg::RC_REINVITE;
            end
          end else if (ent_r.status == sct_pkg::ST_ACK1) begin
            nx.status = sct_pkg::ST_INVITE2;
            rc        = sct_pkg::RC_ADVANCED;
          end else begin
            rc = sct_pkg::RC_BAD_STATE;
          end
        end
        sct_pkg::KIND_ACK: begin
          if (ent_r.status == sct_pkg::ST_AUTHREQ) begin
            nx.status = sct_pkg::ST_ACK1;
            rc        = sct_pkg::RC_ADVANCED;
          end else if ((ent_r.status == sct_pkg::ST_OK1) ||
                       (ent_r.status == sct_pkg::ST_REINVITEOK1)) begin
            nx.status = sct_pkg::ST_ESTABLISHED;
            rc        = sct_pkg::RC_ESTABLISHED;
          end else if (ent_r.status == sct_pkg::ST_SRVUNAVAIL) begin
            rc = sct_pkg::RC_UNCHANGED;
          end else begin
            rc = sct_pkg::RC_BAD_STATE;
          end
        end
        sct_pkg::KIND_BYE: begin
          nx.status = sct_pkg::ST_BYE;
          rc        = sct_pkg::RC_BYE;
        end
        sct_pkg::KIND_STATUS_200: begin
          if ((ent_r.status == sct_pkg::ST_INVITE1) ||
              (ent_r.status == sct_pkg::ST_INVITE2)) begin
            if (!port_ok_r) begin
              rc = sct_pkg::RC_PORT_ERROR;
            end else begin
              if (!direction_r) begin
                nx.remote_port = port_r;
              end else begin
                nx.local_port = port_r;
              end
              nx.status = sct_pkg::ST_OK1;
              rc        = sct_pkg::RC_ADVANCED;
            end
          end else if (ent_r.status == sct_pkg::ST_REINVITE) begin
            nx.status = sct_pkg::ST_REINVITEOK1;
            rc        = sct_pkg::RC_ADVANCED;
          end else if (ent_r.status == sct_pkg::ST_BYE) begin
            // Free the entry; report its last values
            clr_v = 1'b1;
            rc    = sct_pkg::RC_REMOVED;
          end else begin
            rc = sct_pkg::RC_BAD_STATE;
          end
        end
        sct_pkg::KIND_STATUS_407: begin
          nx.status = sct_pkg::ST_AUTHREQ;
          rc        = sct_pkg::RC_ADVANCED;
        end
        default: begin
          nx.status = sct_pkg::ST_SRVUNAVAIL;
          rc        = sct_pkg::RC_ADVANCED;
        end
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (state_r == S_EXEC) begin
      if (set_v) begin
        valid_r[wslot] <= 1'b1;
      end
      if (clr_v) begin
        valid_r[wslot] <= 1'b0;
      end
    end
  end

  // Result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_result_code       <= rc;
      out_session_state     <= touch ? nx.status : 4'd0;
      out_slot              <= touch ? 4'(wslot) : 4'd0;
      out_remote_ip         <= touch ? nx.remote_ip : 32'd0;
      out_local_ip          <= touch ? nx.local_ip : 32'd0;
      out_remote_port       <= touch ? nx.remote_port : 16'd0;
      out_local_port        <= touch ? nx.local_port : 16'd0;
      out_prior_remote_ip   <= prior_ip;
      out_prior_remote_port <= prior_port;
    end
  end

endmodule
